FILE: src/grbf_pkg.sv
// Shared widths, constants and controller/datapath interface types for the RBF kernel unit.
package grbf_pkg;

	localparam int SIG_W        = 16;
	localparam int IN_W         = 16;
	localparam int OUT_W        = 16;
	localparam int SQ_W         = 32;
	localparam int SUM_W        = 44;
	localparam int DEN_W        = 33;
	localparam int REM_W        = 33;
	localparam int QUO_W        = 34;
	localparam int Y_W          = 32;
	localparam int E_W          = 33;
	localparam int N_W          = 4;
	localparam int CNT_W        = 6;
	localparam int SDV_W        = 36;
	localparam int NDIV_BITS    = 4;
	localparam int FRAC_BITS    = 30;

	localparam int DIV_STEPS    = QUO_W;
	localparam int NDIV_CYCLES  = SDV_W / NDIV_BITS;
	localparam int SERIES_TERMS = 13;
	localparam int SQUARINGS    = 4;

	localparam logic [SIG_W-1:0] SIGMA_RESET = 16'd4096;
	localparam logic [E_W-1:0]   ONE_Q32     = 33'h1_0000_0000;

	typedef struct packed {
		logic           capture;
		logic           accum;
		logic           load;
		logic           check;
		logic           div_step;
		logic           series_init;
		logic           mul;
		logic           divn_step;
		logic           divn_first;
		logic           add_term;
		logic           sq_step;
		logic           out_load;
		logic [N_W-1:0] n;
	} grbf_cmd_t;

	typedef struct packed {
		logic cut;
	} grbf_sts_t;

endpackage

FILE: src/grbf_datapath.sv
// Datapath: squared-difference accumulator, distance divider, exp series and squaring.
module grbf_datapath import grbf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  grbf_cmd_t               cmd,
	output grbf_sts_t               sts,
	input  logic signed [IN_W-1:0]  first_value,
	input  logic signed [IN_W-1:0]  second_value,
	input  logic                    cfg_write,
	input  logic [SIG_W-1:0]        sigma,
	output logic [OUT_W-1:0]        kernel_value
);

	logic [SIG_W-1:0] sigma_q;
	logic [DEN_W-1:0] den_q;
	logic [SQ_W-1:0]  sq_s1;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] num_q;
	logic             cut_q;
	logic [REM_W-1:0] rem_q;
	logic [QUO_W-1:0] dvd_q;
	logic [QUO_W-1:0] quo_q;
	logic [Y_W-1:0]   y_q;
	logic [E_W-1:0]   term_q;
	logic [E_W-1:0]   acc_q;
	logic [SDV_W-1:0] sdv_q;
	logic [N_W-1:0]   nrem_q;
	logic [OUT_W-1:0] kernel_q;

	// front end: |a - b|^2
	logic [IN_W:0]    diff;
	logic [IN_W:0]    mag;
	logic [SQ_W-1:0]  sq;
	assign diff = {first_value[IN_W-1], first_value} - {second_value[IN_W-1], second_value};
	assign mag  = diff[IN_W] ? (~diff + 1'b1) : diff;
	assign sq   = mag[IN_W-1:0] * mag[IN_W-1:0];

	// saturating accumulate
	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] sum_sat;
	assign sum_ext = {1'b0, sum_q} + {{(SUM_W-SQ_W+1){1'b0}}, sq_s1};
	assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

	// exp cutoff: sum >= 12 * den
	logic [DEN_W+3:0] thr;
	assign thr = {1'b0, den_q, 3'b000} + {2'b00, den_q, 2'b00};

	// one restoring step of the distance division
	logic [REM_W:0]   trial;
	logic             qbit;
	logic [REM_W:0]   trial_sub;
	assign trial     = {rem_q, dvd_q[QUO_W-1]};
	assign qbit      = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	// four restoring steps of the small divide by n
	logic [SDV_W-1:0] ndv;
	logic [N_W-1:0]   nrem;
	always_comb begin
		logic [N_W:0] t;
		ndv  = cmd.divn_first ? {{(SDV_W-E_W){1'b0}}, term_q} : sdv_q;
		nrem = cmd.divn_first ? '0 : nrem_q;
		for (int j = 0; j < NDIV_BITS; j++) begin
			t   = {nrem, ndv[SDV_W-1]};
			ndv = {ndv[SDV_W-2:0], 1'b0};
			if (t >= {1'b0, cmd.n}) begin
				nrem   = N_W'(t - {1'b0, cmd.n});
				ndv[0] = 1'b1;
			end else begin
				nrem = t[N_W-1:0];
			end
		end
	end

	logic [2*E_W-2:0] prod;
	logic [2*Y_W-1:0] sqp;
	logic [E_W-1:0]   quot;
	logic [E_W:0]     rnd;
	logic [OUT_W+1:0] rvl;
	assign prod = term_q * y_q;
	assign sqp  = acc_q[Y_W-1:0] * acc_q[Y_W-1:0] + {{Y_W{1'b0}}, 1'b1, {(Y_W-1){1'b0}}};
	assign quot = sdv_q[E_W-1:0];
	assign rnd  = {1'b0, acc_q} + {{(E_W-15){1'b0}}, 1'b1, 15'b0};
	assign rvl  = rnd[E_W:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RESET;
			sum_q   <= '0;
		end else begin
			if (cfg_write)
				sigma_q <= sigma;
			if (cmd.load)
				sum_q <= '0;
			else if (cmd.accum)
				sum_q <= sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		den_q <= {32'(sigma_q) * 32'(sigma_q), 1'b0};
		if (cmd.capture)
			sq_s1 <= sq;
		if (cmd.load)
			num_q <= sum_sat;
		if (cmd.check) begin
			cut_q <= (num_q >= {{(SUM_W-DEN_W-4){1'b0}}, thr});
			rem_q <= num_q[REM_W+3:4];
			dvd_q <= {num_q[3:0], {FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], qbit};
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
		end
		if (cmd.series_init) begin
			y_q    <= quo_q[QUO_W-1:2];
			term_q <= ONE_Q32;
			acc_q  <= ONE_Q32;
		end
		if (cmd.mul)
			term_q <= prod[2*E_W-2:32];
		if (cmd.divn_step) begin
			sdv_q  <= ndv;
			nrem_q <= nrem;
		end
		if (cmd.add_term) begin
			term_q <= quot;
			acc_q  <= cmd.n[0] ? (acc_q - quot) : (acc_q + quot);
		end
		if (cmd.sq_step && !acc_q[E_W-1])
			acc_q <= {1'b0, sqp[2*Y_W-1:Y_W]};
		if (cmd.out_load) begin
			if (cut_q)
				kernel_q <= '0;
			else if (|rvl[OUT_W+1:OUT_W])
				kernel_q <= {OUT_W{1'b1}};
			else
				kernel_q <= rvl[OUT_W-1:0];
		end
	end

	assign sts.cut      = cut_q;
	assign kernel_value = kernel_q;

endmodule

FILE: src/grbf_ctrl.sv
// Controller: input handshake, sequencing of the kernel evaluation, output register valid.
module grbf_ctrl import grbf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      last_feature,
	output logic      out_valid,
	input  logic      out_ready,
	input  grbf_sts_t sts,
	output grbf_cmd_t cmd
);

	localparam logic [3:0] S_ACC  = 4'd0;
	localparam logic [3:0] S_LOAD = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_SINI = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_DIVN = 4'd6;
	localparam logic [3:0] S_ADD  = 4'd7;
	localparam logic [3:0] S_SQR  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [N_W-1:0]   n_q, n_d;
	logic             pend_q;
	logic             out_valid_q;
	logic             in_fire;

	assign in_ready = (state_q == S_ACC);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		cmd     = '0;
		cmd.n   = n_q;
		case (state_q)
			S_ACC: begin
				cmd.capture = in_fire;
				cmd.accum   = pend_q;
				if (in_fire && last_feature)
					state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				cmd.check = 1'b1;
				cnt_d     = '0;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (sts.cut) begin
					state_d = S_FIN;
				end else begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_d = S_SINI;
				end
			end
			S_SINI: begin
				cmd.series_init = 1'b1;
				n_d             = N_W'(1);
				state_d         = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = S_DIVN;
			end
			S_DIVN: begin
				cmd.divn_step  = 1'b1;
				cmd.divn_first = (cnt_q == '0);
				cnt_d          = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NDIV_CYCLES - 1))
					state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add_term = 1'b1;
				cnt_d        = '0;
				if (n_q == N_W'(SERIES_TERMS)) begin
					state_d = S_SQR;
				end else begin
					n_d     = n_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_SQR: begin
				cmd.sq_step = 1'b1;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQUARINGS - 1))
					state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_ACC;
				end
			end
			default: state_d = S_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			cnt_q       <= '0;
			n_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			pend_q  <= in_fire && !last_feature;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/gaussian_rbf_kernel_unit.sv
// Top level of the Gaussian RBF kernel unit: controller plus datapath.
//
// Streams feature pairs (signed Q4.12) one transfer per cycle while in_ready is
// high, summing squared differences in a saturating 44-bit accumulator. A pair
// without last_feature leaves in_ready high for the next pair. The transfer
// carrying last_feature starts the kernel evaluation, which closes the input
// until the result is loaded: load and cutoff check, a one-bit-per-cycle
// restoring divide of the distance by 2*sigma^2, series setup, a 13-term
// Taylor series for exp(-x/16) where each term costs one multiply, a serial
// divide by the term index and an add, four squarings and the output register
// load. When x >= 12 the divide, series and squarings are skipped and the
// result is 0. The result sits in an output register, so new feature pairs
// are taken while it waits for its transfer; a second result only waits if
// the first has not left yet. sigma (unsigned Q4.12, reset 1.0) is written
// through cfg_write/sigma and must only change while the unit is idle.
// kernel_value is unsigned Q0.16, 1.0 saturated to 65535.
module gaussian_rbf_kernel_unit import grbf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// feature pair channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IN_W-1:0] first_value,
	input  logic signed [IN_W-1:0] second_value,
	input  logic                   last_feature,
	// kernel result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_W-1:0]       kernel_value,
	// sigma register write
	input  logic                   cfg_write,
	input  logic [SIG_W-1:0]       sigma
);

	grbf_cmd_t cmd;
	grbf_sts_t sts;

	// sequencing, handshakes, counters
	grbf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.last_feature (last_feature),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// arithmetic and the sigma register
	grbf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.first_value  (first_value),
		.second_value (second_value),
		.cfg_write    (cfg_write),
		.sigma        (sigma),
		.kernel_value (kernel_value)
	);

endmodule
